[design/assert_macros.svh]
// Assertion helpers for the register block RTL.
// Define NO_ASSERTIONS to compile every helper to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check prop at every rising clk edge outside reset.
`define OURB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ourb: assertion failed");

// Check that expr is false at every rising clk edge outside reset.
`define OURB_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ourb: forbidden condition seen");

`else

`define OURB_ASSERT(lbl, clk, rst_n, prop)
`define OURB_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[design/ourb_pkg.sv]
package ourb_pkg;

    localparam int NUM_CH         = 8;
    localparam int NUM_BLK        = 4;
    localparam int FIFO_DEPTH_DEF = 3;

    // Item kinds
    localparam logic [1:0] CMD_READ     = 2'd0;
    localparam logic [1:0] CMD_WRITE    = 2'd1;
    localparam logic [1:0] CMD_RX_BYTE  = 2'd2;
    localparam logic [1:0] CMD_RX_BREAK = 2'd3;

    // Register offsets after the byte-lane swap (address bit 0 flipped)
    localparam logic [4:0] REG_MR_A  = 5'h01;
    localparam logic [4:0] REG_MR_B  = 5'h11;
    localparam logic [4:0] REG_SR_A  = 5'h03;
    localparam logic [4:0] REG_SR_B  = 5'h13;
    localparam logic [4:0] REG_CR_A  = 5'h05;
    localparam logic [4:0] REG_CR_B  = 5'h15;
    localparam logic [4:0] REG_HR_A  = 5'h07;
    localparam logic [4:0] REG_HR_B  = 5'h17;
    localparam logic [4:0] REG_ISR   = 5'h0B;
    localparam logic [4:0] LANE_SWAP = 5'h01;

    // Channel status bits
    localparam logic [7:0] ST_RX_READY = 8'h01;
    localparam logic [7:0] ST_TX_READY = 8'h04;
    localparam logic [7:0] SR_TXBITS   = 8'h0C;
    localparam logic [7:0] SR_BRK      = 8'h80;
    localparam logic [7:0] SR_LOW      = 8'h0F;

    // Command register: low enable bits
    localparam int CR_RX_ON  = 0;
    localparam int CR_RX_OFF = 1;
    localparam int CR_TX_ON  = 2;
    localparam int CR_TX_OFF = 3;

    // Command register: high nibble codes
    localparam logic [3:0] CRN_RESET_MR  = 4'h1;
    localparam logic [3:0] CRN_RESET_RX  = 4'h2;
    localparam logic [3:0] CRN_RESET_TX  = 4'h3;
    localparam logic [3:0] CRN_CLR_ERR   = 4'h4;
    localparam logic [3:0] CRN_CLR_BRK   = 4'h5;

    localparam logic [7:0] ISR_BRK_BOTH = 8'h44;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] addr;
        logic [7:0] wdata;
        logic [2:0] rx_channel;
        logic [7:0] rx_data;
    } req_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       tx_valid;
        logic [2:0] tx_channel;
        logic [7:0] tx_data;
        logic       irq_line0;
        logic       irq_line1;
        logic [7:0] rx_space_mask;
        logic       rx_dropped;
    } rsp_t;

    // Interrupt status bit of a channel; odd selects the second channel of a block.
    function automatic logic [7:0] isr_tx_bit(input logic odd);
        return odd ? 8'h10 : 8'h01;
    endfunction

    function automatic logic [7:0] isr_rx_bit(input logic odd);
        return odd ? 8'h20 : 8'h02;
    endfunction

    function automatic logic [7:0] isr_brk_bit(input logic odd);
        return odd ? 8'h40 : 8'h04;
    endfunction

endpackage

[design/octal_uart_register_block_unit.sv]
// Eight-channel UART register block, four blocks of two channels each. Every request item is
// a register read, a register write, a received byte or a received break; every request
// yields exactly one response item carrying read data, an optional transmit byte, the two
// interrupt lines, the per-channel receive space mask and a drop flag. Throughput is one
// item per clock while the output drains: the request is captured in an input register,
// the channel state is read, modified and written back in the same cycle, and the
// response is captured in an output register. A full output register that is not taken
// stalls the input register, which in turn deasserts req_ready; a new request is still
// taken in the cycle the held response leaves. The receive FIFO depth per channel is set
// by FIFO_DEPTH (1 to 3). The valid flags and all channel state clear on reset.
module octal_uart_register_block_unit
    import ourb_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic hold_valid;
    req_t hold;
    logic take;
    rsp_t result;

    // Advance the held request when the response register is free or draining
    assign take = hold_valid && (!rsp_valid || rsp_ready);

    ourb_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .take       (take),
        .hold_valid (hold_valid),
        .hold       (hold)
    );

    // Channel and block state; commits one item per advancing cycle
    ourb_core #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (take),
        .req    (hold),
        .result (result)
    );

    ourb_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .result    (result),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

[design/ourb_in_stage.sv]
module ourb_in_stage
    import ourb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    input  logic take,
    output logic hold_valid,
    output req_t hold
);

    logic hold_valid_reg;
    logic hold_valid_next;
    req_t hold_reg;

    // Refill when empty or when the held item moves on this cycle
    assign req_ready       = !hold_valid_reg || take;
    assign hold_valid_next = req_ready ? req_valid : hold_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            hold_reg <= req;
        end
    end

    assign hold_valid = hold_valid_reg;
    assign hold       = hold_reg;

endmodule

[design/ourb_core.sv]
`include "assert_macros.svh"

module ourb_core
    import ourb_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  req_t req,
    output rsp_t result
);

    localparam int HW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C   = CW'(FIFO_DEPTH);
    localparam logic [SW-1:0] DEPTH_S   = SW'(FIFO_DEPTH);
    localparam logic [HW-1:0] HEAD_LAST = HW'(FIFO_DEPTH - 1);

    logic [NUM_CH-1:0] rx_on_reg,    rx_on_next;
    logic [NUM_CH-1:0] mode_ptr_reg, mode_ptr_next;
    logic [7:0]    mode_reg   [NUM_CH][2];
    logic [7:0]    mode_next  [NUM_CH][2];
    logic [7:0]    status_reg [NUM_CH];
    logic [7:0]    status_next[NUM_CH];
    logic [7:0]    fifo_reg   [NUM_CH][FIFO_DEPTH];
    logic [7:0]    fifo_next  [NUM_CH][FIFO_DEPTH];
    logic [HW-1:0] head_reg   [NUM_CH];
    logic [HW-1:0] head_next  [NUM_CH];
    logic [CW-1:0] count_reg  [NUM_CH];
    logic [CW-1:0] count_next [NUM_CH];
    logic [7:0]    isr_reg    [NUM_BLK];
    logic [7:0]    isr_next   [NUM_BLK];
    logic [7:0]    imr_reg    [NUM_BLK];
    logic [7:0]    imr_next   [NUM_BLK];

    logic [2:0]    ch;
    logic [1:0]    blk;
    logic [4:0]    off;
    logic [2:0]    rch;
    logic [1:0]    rblk;
    logic [SW-1:0] pos_sum;
    logic [HW-1:0] pos;
    logic [7:0]    rx_byte;
    rsp_t          rsp_next;
    logic          count_over;
    logic          rxrdy_mismatch;
    logic          drop_ok;
    logic          tx_ok;

    assign ch   = req.addr[6:4];
    assign blk  = req.addr[6:5];
    assign off  = req.addr[4:0] ^ LANE_SWAP;
    assign rch  = req.rx_channel;
    assign rblk = req.rx_channel[2:1];

    // Write slot of a received byte: head plus fill, wrapped once
    assign pos_sum = SW'(head_reg[rch]) + SW'(count_reg[rch]);
    assign pos     = (pos_sum >= DEPTH_S) ? HW'(pos_sum - DEPTH_S) : HW'(pos_sum);
    assign rx_byte = (req.cmd == CMD_RX_BYTE) ? req.rx_data : 8'h00;

    always_comb
    begin
        rx_on_next    = rx_on_reg;
        mode_ptr_next = mode_ptr_reg;
        mode_next     = mode_reg;
        status_next   = status_reg;
        fifo_next     = fifo_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        isr_next      = isr_reg;
        imr_next      = imr_reg;
        rsp_next      = '0;

        case (req.cmd)
            CMD_READ:
            begin
                case (off)
                    REG_MR_A, REG_MR_B:
                    begin
                        rsp_next.rdata    = mode_reg[ch][mode_ptr_reg[ch]];
                        mode_ptr_next[ch] = 1'b1;
                    end
                    REG_SR_A, REG_SR_B:
                    begin
                        rsp_next.rdata = status_reg[ch];
                    end
                    REG_HR_A, REG_HR_B:
                    begin
                        rsp_next.rdata = fifo_reg[ch][head_reg[ch]];
                        if (count_reg[ch] != '0)
                        begin
                            count_next[ch] = count_reg[ch] - 1'b1;
                            if (count_next[ch] == '0)
                            begin
                                status_next[ch] = status_next[ch] & ~ST_RX_READY;
                                isr_next[blk]   = isr_next[blk] & ~isr_rx_bit(ch[0]);
                            end
                            else
                            begin
                                head_next[ch] = (head_reg[ch] == HEAD_LAST) ? '0
                                                : head_reg[ch] + 1'b1;
                            end
                            // Break condition reaches the interrupt when its char is taken
                            if ((status_next[ch] & SR_BRK) != '0)
                            begin
                                status_next[ch] = status_next[ch] & ~SR_BRK;
                                isr_next[blk]   = isr_next[blk] | isr_brk_bit(ch[0]);
                            end
                        end
                    end
                    REG_ISR:
                    begin
                        rsp_next.rdata = isr_reg[blk];
                    end
                    default:
                    begin
                    end
                endcase
            end

            CMD_WRITE:
            begin
                case (off)
                    REG_MR_A, REG_MR_B:
                    begin
                        mode_next[ch][mode_ptr_reg[ch]] = req.wdata;
                        mode_ptr_next[ch]               = 1'b1;
                    end
                    REG_CR_A, REG_CR_B:
                    begin
                        if (req.wdata[CR_RX_ON])
                        begin
                            rx_on_next[ch] = 1'b1;
                        end
                        if (req.wdata[CR_RX_OFF])
                        begin
                            rx_on_next[ch] = 1'b0;
                        end
                        if (req.wdata[CR_TX_ON])
                        begin
                            status_next[ch] = status_next[ch] | SR_TXBITS;
                            isr_next[blk]   = isr_next[blk] | isr_tx_bit(ch[0]);
                        end
                        if (req.wdata[CR_TX_OFF])
                        begin
                            status_next[ch] = status_next[ch] & ~SR_TXBITS;
                            isr_next[blk]   = isr_next[blk] & ~isr_tx_bit(ch[0]);
                        end
                        case (req.wdata[7:4])
                            CRN_RESET_MR:
                            begin
                                mode_ptr_next[ch] = 1'b0;
                            end
                            CRN_RESET_RX:
                            begin
                                rx_on_next[ch]  = 1'b0;
                                count_next[ch]  = '0;
                                status_next[ch] = status_next[ch] & ~ST_RX_READY;
                                isr_next[blk]   = isr_next[blk] & ~isr_rx_bit(ch[0]);
                            end
                            CRN_RESET_TX:
                            begin
                                status_next[ch] = status_next[ch] & ~SR_TXBITS;
                                isr_next[blk]   = isr_next[blk] & ~isr_tx_bit(ch[0]);
                            end
                            CRN_CLR_ERR:
                            begin
                                status_next[ch] = status_next[ch] & SR_LOW;
                            end
                            CRN_CLR_BRK:
                            begin
                                isr_next[blk] = isr_next[blk] & ~ISR_BRK_BOTH;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    REG_HR_A, REG_HR_B:
                    begin
                        if ((status_reg[ch] & ST_TX_READY) != '0)
                        begin
                            rsp_next.tx_valid   = 1'b1;
                            rsp_next.tx_channel = ch;
                            rsp_next.tx_data    = req.wdata;
                        end
                    end
                    REG_ISR:
                    begin
                        imr_next[blk] = req.wdata;
                    end
                    default:
                    begin
                    end
                endcase
            end

            CMD_RX_BYTE, CMD_RX_BREAK:
            begin
                if (req.cmd == CMD_RX_BREAK && (status_reg[rch] & SR_BRK) == '0)
                begin
                    status_next[rch] = status_next[rch] | SR_BRK;
                    isr_next[rblk]   = isr_next[rblk] | isr_brk_bit(rch[0]);
                end
                if (!rx_on_reg[rch] || count_reg[rch] >= DEPTH_C)
                begin
                    rsp_next.rx_dropped = 1'b1;
                end
                else
                begin
                    fifo_next[rch][pos] = rx_byte;
                    count_next[rch]     = count_reg[rch] + 1'b1;
                    if ((status_next[rch] & ST_RX_READY) == '0)
                    begin
                        isr_next[rblk]   = isr_next[rblk] | isr_rx_bit(rch[0]);
                        status_next[rch] = status_next[rch] | ST_RX_READY;
                    end
                end
            end

            default:
            begin
            end
        endcase

        // Interrupt lines and receive space follow the updated state
        rsp_next.irq_line0 = |((isr_next[0] & imr_next[0]) | (isr_next[1] & imr_next[1]));
        rsp_next.irq_line1 = |((isr_next[2] & imr_next[2]) | (isr_next[3] & imr_next[3]));
        for (int i = 0; i < NUM_CH; i++)
        begin
            rsp_next.rx_space_mask[i] = rx_on_next[i] && (count_next[i] < DEPTH_C);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_on_reg    <= '0;
            mode_ptr_reg <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                mode_reg[i][0] <= '0;
                mode_reg[i][1] <= '0;
                status_reg[i]  <= '0;
                head_reg[i]    <= '0;
                count_reg[i]   <= '0;
                for (int j = 0; j < FIFO_DEPTH; j++)
                begin
                    fifo_reg[i][j] <= '0;
                end
            end
            for (int k = 0; k < NUM_BLK; k++)
            begin
                isr_reg[k] <= '0;
                imr_reg[k] <= '0;
            end
        end
        else if (step)
        begin
            rx_on_reg    <= rx_on_next;
            mode_ptr_reg <= mode_ptr_next;
            mode_reg     <= mode_next;
            status_reg   <= status_next;
            fifo_reg     <= fifo_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            isr_reg      <= isr_next;
            imr_reg      <= imr_next;
        end
    end

    assign result = rsp_next;

    // Invariants over the channel state
    always_comb
    begin
        count_over     = 1'b0;
        rxrdy_mismatch = 1'b0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (count_reg[i] > DEPTH_C)
            begin
                count_over = 1'b1;
            end
            if (((status_reg[i] & ST_RX_READY) != '0) != (count_reg[i] != '0))
            begin
                rxrdy_mismatch = 1'b1;
            end
        end
    end

    // A drop comes only from a receive event, a transmit only from a ready write
    assign drop_ok = !(step && result.rx_dropped)
                     || req.cmd == CMD_RX_BYTE || req.cmd == CMD_RX_BREAK;
    assign tx_ok   = !(step && result.tx_valid)
                     || (req.cmd == CMD_WRITE && (status_reg[ch] & ST_TX_READY) != 8'h00);

    `OURB_ASSERT_NEVER(a_fifo_count_bound, clk, rst_n, count_over)
    `OURB_ASSERT_NEVER(a_rxrdy_tracks_fill, clk, rst_n, rxrdy_mismatch)
    `OURB_ASSERT(a_drop_only_on_rx, clk, rst_n, drop_ok)
    `OURB_ASSERT(a_tx_needs_ready, clk, rst_n, tx_ok)

endmodule

[design/ourb_out_stage.sv]
module ourb_out_stage
    import ourb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  rsp_t result,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;

    // Load a new item, else drop the current one once taken
    assign rsp_valid_next = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[sim/octal_uart_register_block_unit_test.sv]
module octal_uart_register_block_unit_test
    import ourb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RX_DEPTH    = FIFO_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PRINT_LIMIT = 100;
    localparam int REQ_W       = $bits(req_t);

    // Interrupt status bits of the first channel in a block; the second channel
    // uses the same bits shifted up by four.
    localparam logic [7:0] ISR_TX_A  = 8'h01;
    localparam logic [7:0] ISR_RX_A  = 8'h02;
    localparam logic [7:0] ISR_BRK_A = 8'h04;

    // Command byte pieces: low enable bits and the high-nibble codes not in the package.
    localparam logic [3:0] EN_NONE   = 4'h0;
    localparam logic [3:0] EN_RX_ON  = 4'(1 << CR_RX_ON);
    localparam logic [3:0] EN_RX_OFF = 4'(1 << CR_RX_OFF);
    localparam logic [3:0] EN_TX_ON  = 4'(1 << CR_TX_ON);
    localparam logic [3:0] EN_TX_OFF = 4'(1 << CR_TX_OFF);
    localparam logic [3:0] CRN_NONE   = 4'h0;
    localparam logic [3:0] CRN_UNUSED = 4'hF;

    // A register offset that decodes to nothing on reads and writes.
    localparam logic [4:0] REG_SPARE = 5'h09;

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Shadow copy of the register block state.
    logic       rx_en      [NUM_CH]       = '{default: '0};
    logic [7:0] mode_mem   [NUM_CH * 2]   = '{default: '0};
    logic       mode_sel   [NUM_CH]       = '{default: '0};
    logic [7:0] ch_status  [NUM_CH]       = '{default: '0};
    logic [7:0] fifo_mem   [NUM_CH * 3]   = '{default: '0};
    logic [1:0] fifo_head  [NUM_CH]       = '{default: '0};
    logic [1:0] fifo_cnt   [NUM_CH]       = '{default: '0};
    logic [7:0] irq_status [NUM_BLK]      = '{default: '0};
    logic [7:0] irq_mask   [NUM_BLK]      = '{default: '0};

    rsp_t owed_responses[$];

    int unsigned cycle_count     = 0;
    int unsigned mismatch_count  = 0;
    int unsigned items_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned tx_bytes_seen   = 0;
    int unsigned drops_seen      = 0;

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int hold_left     = 0;

    octal_uart_register_block_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow model of the register block
    // ------------------------------------------------------------------

    // Move a first-channel interrupt bit to the lane of channel c.
    function automatic logic [7:0] chan_bit(input logic [2:0] c, input logic [7:0] base);
        return c[0] ? (base << 4) : base;
    endfunction

    // Queue a received character; return 1 when it has to be dropped.
    function automatic logic push_rx(input logic [2:0] c, input logic [7:0] d);
        int pos;
        if (!rx_en[c] || fifo_cnt[c] >= RX_DEPTH)
            return 1'b1;
        pos = (fifo_head[c] + fifo_cnt[c]) % RX_DEPTH;
        fifo_mem[int'(c) * 3 + pos] = d;
        fifo_cnt[c] = fifo_cnt[c] + 2'd1;
        if ((ch_status[c] & ST_RX_READY) == '0)
        begin
            irq_status[c[2:1]] |= chan_bit(c, ISR_RX_A);
            ch_status[c] |= ST_RX_READY;
        end
        return 1'b0;
    endfunction

    // Apply a command register write: enable bits first, then the high nibble.
    function automatic void apply_command(input logic [2:0] c, input logic [7:0] v);
        logic [1:0] b;
        b = c[2:1];
        if (v[CR_RX_ON])
            rx_en[c] = 1'b1;
        if (v[CR_RX_OFF])
            rx_en[c] = 1'b0;
        if (v[CR_TX_ON])
        begin
            ch_status[c] |= SR_TXBITS;
            irq_status[b] |= chan_bit(c, ISR_TX_A);
        end
        if (v[CR_TX_OFF])
        begin
            ch_status[c] &= ~SR_TXBITS;
            irq_status[b] &= ~chan_bit(c, ISR_TX_A);
        end
        case (v[7:4])
            CRN_RESET_MR: mode_sel[c] = 1'b0;
            CRN_RESET_RX:
            begin
                rx_en[c] = 1'b0;
                fifo_cnt[c] = 2'd0;
                ch_status[c] &= ~ST_RX_READY;
                irq_status[b] &= ~chan_bit(c, ISR_RX_A);
            end
            CRN_RESET_TX:
            begin
                ch_status[c] &= ~SR_TXBITS;
                irq_status[b] &= ~chan_bit(c, ISR_TX_A);
            end
            CRN_CLR_ERR: ch_status[c] &= SR_LOW;
            CRN_CLR_BRK: irq_status[b] &= ~ISR_BRK_BOTH;
            default: ;
        endcase
    endfunction

    // Advance the shadow state by one accepted item and return the response it owes.
    function automatic rsp_t next_uart_response(input req_t r);
        rsp_t y;
        logic [2:0] c;
        logic [1:0] b;
        logic [4:0] off;
        logic [2:0] rc;
        y = '0;
        c = r.addr[6:4];
        b = r.addr[6:5];
        off = r.addr[4:0] ^ LANE_SWAP;
        rc = r.rx_channel;
        case (r.cmd)
            CMD_READ:
                case (off)
                    REG_MR_A, REG_MR_B:
                    begin
                        y.rdata = mode_mem[{c, mode_sel[c]}];
                        mode_sel[c] = 1'b1;
                    end
                    REG_SR_A, REG_SR_B: y.rdata = ch_status[c];
                    REG_HR_A, REG_HR_B:
                    begin
                        // An empty FIFO still returns whatever sits at the head.
                        y.rdata = fifo_mem[int'(c) * 3 + int'(fifo_head[c])];
                        if (fifo_cnt[c] != 2'd0)
                        begin
                            fifo_cnt[c] = fifo_cnt[c] - 2'd1;
                            if (fifo_cnt[c] == 2'd0)
                            begin
                                ch_status[c] &= ~ST_RX_READY;
                                irq_status[b] &= ~chan_bit(c, ISR_RX_A);
                            end
                            else
                                fifo_head[c] = 2'((fifo_head[c] + 1) % RX_DEPTH);
                            // A pending break moves from the status byte to the ISR.
                            if ((ch_status[c] & SR_BRK) != '0)
                            begin
                                ch_status[c] &= ~SR_BRK;
                                irq_status[b] |= chan_bit(c, ISR_BRK_A);
                            end
                        end
                    end
                    REG_ISR: y.rdata = irq_status[b];
                    default: ;
                endcase
            CMD_WRITE:
                case (off)
                    REG_MR_A, REG_MR_B:
                    begin
                        mode_mem[{c, mode_sel[c]}] = r.wdata;
                        mode_sel[c] = 1'b1;
                    end
                    REG_CR_A, REG_CR_B: apply_command(c, r.wdata);
                    REG_HR_A, REG_HR_B:
                        if ((ch_status[c] & ST_TX_READY) != '0)
                        begin
                            y.tx_valid = 1'b1;
                            y.tx_channel = c;
                            y.tx_data = r.wdata;
                        end
                    REG_ISR: irq_mask[b] = r.wdata;
                    default: ;
                endcase
            CMD_RX_BYTE: y.rx_dropped = push_rx(rc, r.rx_data);
            CMD_RX_BREAK:
            begin
                // The break flags are set even when its zero character is dropped.
                if ((ch_status[rc] & SR_BRK) == '0)
                begin
                    ch_status[rc] |= SR_BRK;
                    irq_status[rc[2:1]] |= chan_bit(rc, ISR_BRK_A);
                end
                y.rx_dropped = push_rx(rc, 8'h00);
            end
            default: ;
        endcase
        for (int i = 0; i < NUM_CH; i++)
            y.rx_space_mask[i] = rx_en[i] && (fifo_cnt[i] < RX_DEPTH);
        y.irq_line0 = |((irq_status[0] & irq_mask[0]) | (irq_status[1] & irq_mask[1]));
        y.irq_line1 = |((irq_status[2] & irq_mask[2]) | (irq_status[3] & irq_mask[3]));
        return y;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------

    // Start from an item with every field random so unused fields toggle too.
    function automatic req_t noise_item();
        logic [REQ_W-1:0] raw;
        raw = REQ_W'($urandom);
        return req_t'(raw);
    endfunction

    // Bus access to a register of channel ch; off is the first-channel offset.
    function automatic req_t bus_item(input logic [1:0] kind, input logic [2:0] ch,
                                      input logic [4:0] off, input logic [7:0] data);
        req_t r;
        r = noise_item();
        r.cmd = kind;
        r.addr = {ch[2:1], (off | {ch[0], 4'h0}) ^ LANE_SWAP};
        r.wdata = data;
        return r;
    endfunction

    function automatic req_t rx_item(input logic [1:0] kind, input logic [2:0] ch,
                                     input logic [7:0] data);
        req_t r;
        r = noise_item();
        r.cmd = kind;
        r.rx_channel = ch;
        r.rx_data = data;
        return r;
    endfunction

    // Command byte leaning toward enables so that traffic gets past the idle state.
    function automatic logic [7:0] command_byte();
        logic [3:0] low;
        low = 4'($urandom);
        case ($urandom_range(12))
            0, 1, 2: return {CRN_NONE, EN_RX_ON | EN_TX_ON};
            3:       return {CRN_NONE, EN_RX_ON};
            4:       return {CRN_NONE, EN_TX_ON};
            5:       return {CRN_NONE, EN_RX_OFF};
            6:       return {CRN_NONE, EN_TX_OFF};
            7:       return {CRN_RESET_MR, low};
            8:       return {CRN_RESET_RX, low};
            9:       return {CRN_RESET_TX, low};
            10:      return {CRN_CLR_ERR, low};
            11:      return {CRN_CLR_BRK, low};
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed register traffic and receive events, some pure noise.
    function automatic req_t random_item();
        logic [2:0] ch;
        logic [2:0] blk_ch;
        logic [7:0] v;
        ch = 3'($urandom_range(7));
        blk_ch = {ch[2:1], 1'b0};
        v = 8'($urandom);
        case ($urandom_range(19))
            0, 1, 2, 3: return rx_item(CMD_RX_BYTE, ch, v);
            4:          return rx_item(CMD_RX_BREAK, ch, v);
            5, 6, 7:    return bus_item(CMD_READ, ch, REG_HR_A, v);
            8:          return bus_item(CMD_READ, ch, REG_SR_A, v);
            9:          return bus_item(CMD_READ, ch, REG_MR_A, v);
            10:         return bus_item(CMD_READ, blk_ch, REG_ISR, v);
            11, 12, 13: return bus_item(CMD_WRITE, ch, REG_CR_A, command_byte());
            14, 15:     return bus_item(CMD_WRITE, ch, REG_HR_A, v);
            16:         return bus_item(CMD_WRITE, ch, REG_MR_A, v);
            17:         return bus_item(CMD_WRITE, blk_ch, REG_ISR, v);
            default:    return noise_item();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one item after a random gap; hold it until the block takes it.
    task automatic send_item(input req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Drop valid once the last item of a burst is taken.
    task automatic release_sender();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    // Hold the sender until every owed response has arrived.
    task automatic wait_results_done();
        while (owed_responses.size() != 0)
            @(negedge clk);
    endtask

    // Receiver: stall at random, or hold off completely while a hold-off is pending.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ready <= 1'b0;
            hold_left--;
        end
        else
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH cycle %0d response %0d: %s", cycle_count, results_checked, what);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Sample both handshakes at the rising edge; predict on request accept,
    // compare on response accept.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                owed_responses.push_back(next_uart_response(req));
                items_accepted++;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (owed_responses.size() == 0)
                    report_mismatch("response arrived with nothing outstanding");
                else
                begin
                    want = owed_responses.pop_front();
                    check_field("rdata", rsp.rdata, want.rdata);
                    check_field("tx_valid", 8'(rsp.tx_valid), 8'(want.tx_valid));
                    check_field("tx_channel", 8'(rsp.tx_channel), 8'(want.tx_channel));
                    check_field("tx_data", rsp.tx_data, want.tx_data);
                    check_field("irq_line0", 8'(rsp.irq_line0), 8'(want.irq_line0));
                    check_field("irq_line1", 8'(rsp.irq_line1), 8'(want.irq_line1));
                    check_field("rx_space_mask", rsp.rx_space_mask, want.rx_space_mask);
                    check_field("rx_dropped", 8'(rsp.rx_dropped), 8'(want.rx_dropped));
                    tx_bytes_seen += 32'(want.tx_valid);
                    drops_seen += 32'(want.rx_dropped);
                    results_checked++;
                end
            end
        end
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses owed",
                     cycle_count, owed_responses.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic apply_reset();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    endtask

    // Mode register pointer, pointer reset, and registers that decode to nothing.
    task automatic test_mode_registers();
        send_item(bus_item(CMD_READ, 3'd0, REG_MR_A, 8'h00));
        send_item(bus_item(CMD_WRITE, 3'd0, REG_MR_A, 8'hFF));
        send_item(bus_item(CMD_WRITE, 3'd0, REG_CR_A, {CRN_RESET_MR, EN_NONE}));
        send_item(bus_item(CMD_WRITE, 3'd0, REG_MR_A, 8'hA5));
        send_item(bus_item(CMD_READ, 3'd0, REG_MR_A, 8'h00));
        send_item(bus_item(CMD_WRITE, 3'd7, REG_SPARE, 8'hFF));
        send_item(bus_item(CMD_READ, 3'd7, REG_SPARE, 8'h00));
        send_item(bus_item(CMD_WRITE, 3'd7, REG_SR_A, 8'hFF));
    endtask

    // Transmit while not ready, enable, send, then reset the transmitter.
    task automatic test_transmit();
        send_item(bus_item(CMD_WRITE, 3'd3, REG_HR_A, 8'h55));
        send_item(bus_item(CMD_WRITE, 3'd2, REG_ISR, 8'hFF));
        send_item(bus_item(CMD_WRITE, 3'd3, REG_CR_A, {CRN_NONE, EN_TX_ON}));
        send_item(bus_item(CMD_WRITE, 3'd3, REG_HR_A, 8'hFF));
        send_item(bus_item(CMD_WRITE, 3'd3, REG_CR_A, {CRN_RESET_TX, EN_NONE}));
        send_item(bus_item(CMD_WRITE, 3'd3, REG_HR_A, 8'hAA));
    endtask

    // Drop while disabled, fill, break into a full FIFO, drain past empty, clears.
    task automatic test_receive_fifo();
        send_item(rx_item(CMD_RX_BYTE, 3'd5, 8'h11));
        send_item(bus_item(CMD_WRITE, 3'd4, REG_ISR, 8'hFF));
        send_item(bus_item(CMD_WRITE, 3'd5, REG_CR_A, {CRN_NONE, EN_RX_ON}));
        send_item(rx_item(CMD_RX_BYTE, 3'd5, 8'h00));
        send_item(rx_item(CMD_RX_BYTE, 3'd5, 8'hFF));
        send_item(rx_item(CMD_RX_BYTE, 3'd5, 8'h5A));
        send_item(rx_item(CMD_RX_BREAK, 3'd5, 8'hFF));
        send_item(bus_item(CMD_READ, 3'd5, REG_SR_A, 8'h00));
        repeat (4) send_item(bus_item(CMD_READ, 3'd5, REG_HR_A, 8'h00));
        send_item(bus_item(CMD_WRITE, 3'd5, REG_CR_A, {CRN_CLR_BRK, EN_NONE}));
        send_item(bus_item(CMD_WRITE, 3'd5, REG_CR_A, {CRN_CLR_ERR, EN_NONE}));
        send_item(bus_item(CMD_WRITE, 3'd5, REG_CR_A, {CRN_UNUSED, EN_RX_ON}));
        send_item(bus_item(CMD_WRITE, 3'd5, REG_CR_A, {CRN_RESET_RX, EN_NONE}));
    endtask

    // One phase of random traffic under the given idle and stall rates.
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        repeat (count) send_item(random_item());
        release_sender();
        wait_results_done();
    endtask

    // Hold the receiver off while items keep coming, so the block fills and
    // stalls its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        send_item(random_item());
        hold_left = 80;
        repeat (30) send_item(random_item());
        release_sender();
        wait_results_done();
    endtask

    initial
    begin
        apply_reset();

        test_mode_registers();
        test_transmit();
        test_receive_fifo();
        release_sender();
        wait_results_done();

        test_random_traffic(240, 0, 0);
        test_random_traffic(220, 66, 0);
        test_backpressure();
        test_random_traffic(220, 0, 66);
        test_random_traffic(220, 25, 25);

        // Let any stray response show up before the verdict.
        repeat (10) @(posedge clk);

        $display("Run covered %0d items of register traffic, receive bytes and breaks,",
                 items_accepted);
        $display("  %0d responses checked, %0d transmits, %0d drops, %0d mismatches",
                 results_checked, tx_bytes_seen, drops_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
